// ===== rtl/core/lsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsw_pkg - shared types and constants of the lap stopwatch
// command codes, mode codes, status bundle and reciprocal constants used by
// the control stage and the time formatting pipeline
// ----------------------------------------------------------------------------
package lsw_pkg;

	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_RESET   = 3'd1;
	localparam logic [2:0] OP_TOGGLE  = 3'd2;
	localparam logic [2:0] OP_REFRESH = 3'd3;
	localparam logic [2:0] OP_LAP     = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;
	localparam logic [2:0] OP_FORMAT  = 3'd6;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_PAUSE = 2'd2;

	// floor(x/1000) = ((x >> 3) * RECIP_125) >> 36, exact for 32-bit x
	localparam logic [29:0] RECIP_125 = 30'd549755814;
	// floor(q/60) = ((q >> 2) * RECIP_15) >> 25, exact for 23-bit q
	localparam logic [21:0] RECIP_15  = 22'd2236963;
	// floor(r/10) = (r * RECIP_10) >> 11, exact for r below 1000
	localparam logic [7:0]  RECIP_10  = 8'd205;
	localparam logic [7:0]  MIN_SAT   = 8'd255;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] elapsed;
		logic [3:0]  lap_count;
		logic        lap_valid;
	} stat_t;

endpackage

// ===== rtl/core/lsw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsw_ctrl - stopwatch state and lap memory
// applies one command per transfer, keeps laps in a circular buffer and
// registers the status and selected time for the formatting pipeline
// ----------------------------------------------------------------------------
module lsw_ctrl #(
	parameter int LAP_DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [2:0]           op,
	input  logic [31:0]          now,
	input  logic [2:0]           lap_index,
	input  logic [31:0]          time_value,
	output lsw_pkg::stat_t       stat_s2,
	output logic [31:0]          shown_s2
);

	localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int CW = $clog2(LAP_DEPTH + 1);
	localparam int SW = AW + 4;
	localparam logic [SW-1:0] DEPTH_S = SW'(LAP_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(LAP_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(LAP_DEPTH - 1);

	logic [1:0]    mode_q, mode_nxt;
	logic [31:0]   start_q, start_nxt;
	logic [31:0]   held_q, held_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic [AW-1:0] head_q, head_nxt;

	logic [31:0]   mem [LAP_DEPTH];
	logic [31:0]   rd_s2;
	logic [31:0]   tv_s2;
	logic [2:0]    op_s2;

	logic [31:0]   diff;
	logic          full;
	logic          lap_ok;
	logic [SW-1:0] sum_rd, sum_wr, wrap_rd, wrap_wr;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   cnt_ext;

	assign diff = now - start_q;
	assign full = (count_q == DEPTH_C);
	assign lap_ok = (8'(lap_index) < 8'(count_q));

	// circular buffer addressing, oldest lap sits at head
	assign sum_rd  = SW'(head_q) + SW'(lap_index);
	assign sum_wr  = SW'(head_q) + SW'(count_q);
	assign wrap_rd = (sum_rd >= DEPTH_S) ? (sum_rd - DEPTH_S) : sum_rd;
	assign wrap_wr = (sum_wr >= DEPTH_S) ? (sum_wr - DEPTH_S) : sum_wr;
	assign rd_addr = lap_ok ? wrap_rd[AW-1:0] : '0;
	assign wr_addr = full ? head_q : wrap_wr[AW-1:0];

	always_comb begin
		mode_nxt  = mode_q;
		start_nxt = start_q;
		held_nxt  = held_q;
		count_nxt = count_q;
		head_nxt  = head_q;
		case (op)
			lsw_pkg::OP_START: begin
				mode_nxt  = lsw_pkg::MODE_RUN;
				held_nxt  = '0;
				start_nxt = now;
			end
			lsw_pkg::OP_RESET: begin
				mode_nxt  = lsw_pkg::MODE_IDLE;
				held_nxt  = '0;
				count_nxt = '0;
				head_nxt  = '0;
			end
			lsw_pkg::OP_TOGGLE: begin
				if (mode_q == lsw_pkg::MODE_RUN) begin
					held_nxt = diff;
					mode_nxt = lsw_pkg::MODE_PAUSE;
				end else if (mode_q == lsw_pkg::MODE_PAUSE) begin
					start_nxt = now - held_q;
					mode_nxt  = lsw_pkg::MODE_RUN;
				end
			end
			lsw_pkg::OP_REFRESH: begin
				if (mode_q == lsw_pkg::MODE_RUN) begin
					held_nxt = diff;
				end
			end
			lsw_pkg::OP_LAP: begin
				if (mode_q == lsw_pkg::MODE_RUN) begin
					held_nxt = diff;
				end
				if (full) begin
					// drop the oldest lap by moving the head
					head_nxt = (head_q == LAST_A) ? '0 : head_q + AW'(1);
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lsw_pkg::MODE_IDLE;
			start_q <= '0;
			held_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
		end else if (adv) begin
			mode_q  <= mode_nxt;
			start_q <= start_nxt;
			held_q  <= held_nxt;
			count_q <= count_nxt;
			head_q  <= head_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (op == lsw_pkg::OP_LAP)) begin
			mem[wr_addr] <= held_nxt;
		end
	end

	assign cnt_ext = 32'(count_nxt);

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s2             <= mem[rd_addr];
			op_s2             <= op;
			tv_s2             <= time_value;
			stat_s2.mode      <= mode_nxt;
			stat_s2.elapsed   <= held_nxt;
			stat_s2.lap_count <= cnt_ext[3:0];
			stat_s2.lap_valid <= (op == lsw_pkg::OP_READ) && lap_ok;
		end
	end

	always_comb begin
		if (op_s2 == lsw_pkg::OP_READ) begin
			shown_s2 = stat_s2.lap_valid ? rd_s2 : '0;
		end else if (op_s2 == lsw_pkg::OP_FORMAT) begin
			shown_s2 = tv_s2;
		end else begin
			shown_s2 = stat_s2.elapsed;
		end
	end

	// the head only moves once the store has filled
	a_head_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != DEPTH_C) |-> (head_q == '0))
		else $error("lap head moved before store filled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= DEPTH_C) && (head_q <= LAST_A))
		else $error("lap count or head out of range");

	a_reset_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (op == lsw_pkg::OP_RESET)) |=> (count_q == '0) && (mode_q == lsw_pkg::MODE_IDLE))
		else $error("reset command did not clear laps");

endmodule

// ===== rtl/core/lsw_fmt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsw_fmt - minutes, seconds and hundredths split
// three stage pipeline of reciprocal multiplies with per stage flow control
// ----------------------------------------------------------------------------
module lsw_fmt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lsw_pkg::stat_t stat_in,
	input  logic [31:0]    shown_in,
	output logic           out_valid,
	input  logic           out_ready,
	output lsw_pkg::stat_t stat_out,
	output logic [31:0]    shown_out,
	output logic [7:0]     minutes,
	output logic [5:0]     seconds,
	output logic [6:0]     hundredths
);

	logic v_s3, v_s4, v_s5;
	logic r_s3, r_s4, r_s5;

	lsw_pkg::stat_t stat_s3, stat_s4, stat_s5;
	logic [31:0]    shown_s3, shown_s4, shown_s5;
	logic [22:0]    q_s3, q_s4;
	logic [16:0]    qm_s4;
	logic [9:0]     rem_s4;
	logic [7:0]     min_s5;
	logic [5:0]     sec_s5;
	logic [6:0]     hun_s5;

	logic [58:0]    p_1000;
	logic [42:0]    p_60;
	logic [31:0]    rem_full;
	logic [22:0]    sec_full;
	logic [18:0]    p_10;

	assign r_s5 = !v_s5 || out_ready;
	assign r_s4 = !v_s4 || r_s5;
	assign r_s3 = !v_s3 || r_s4;
	assign in_ready = r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (r_s3) v_s3 <= in_valid;
			if (r_s4) v_s4 <= v_s3;
			if (r_s5) v_s5 <= v_s4;
		end
	end

	// whole seconds
	assign p_1000 = 59'(shown_in[31:3]) * 59'(lsw_pkg::RECIP_125);

	always_ff @(posedge clk) begin
		if (in_valid && r_s3) begin
			stat_s3  <= stat_in;
			shown_s3 <= shown_in;
			q_s3     <= p_1000[58:36];
		end
	end

	// whole minutes and millisecond remainder
	assign p_60     = 43'(q_s3[22:2]) * 43'(lsw_pkg::RECIP_15);
	assign rem_full = shown_s3 - (32'(q_s3) * 32'd1000);

	always_ff @(posedge clk) begin
		if (v_s3 && r_s4) begin
			stat_s4  <= stat_s3;
			shown_s4 <= shown_s3;
			q_s4     <= q_s3;
			qm_s4    <= p_60[41:25];
			rem_s4   <= rem_full[9:0];
		end
	end

	assign sec_full = q_s4 - (23'(qm_s4) * 23'd60);
	assign p_10     = 19'(rem_s4) * 19'(lsw_pkg::RECIP_10);

	always_ff @(posedge clk) begin
		if (v_s4 && r_s5) begin
			stat_s5  <= stat_s4;
			shown_s5 <= shown_s4;
			min_s5   <= (qm_s4 > 17'(lsw_pkg::MIN_SAT)) ? lsw_pkg::MIN_SAT : qm_s4[7:0];
			sec_s5   <= sec_full[5:0];
			hun_s5   <= p_10[17:11];
		end
	end

	assign out_valid  = v_s5;
	assign stat_out   = stat_s5;
	assign shown_out  = shown_s5;
	assign minutes    = min_s5;
	assign seconds    = sec_s5;
	assign hundredths = hun_s5;

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (sec_s5 < 6'd60) && (hun_s5 < 7'd100))
		else $error("formatted digits out of range");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem_s4 < 10'd1000))
		else $error("millisecond remainder out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !out_ready) |=> v_s5 && $stable(shown_s5))
		else $error("stalled result changed");

endmodule

// ===== rtl/core/lap_stopwatch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap_stopwatch - millisecond stopwatch with lap memory
// runs commands against a free-running tick, keeps the newest laps and
// splits the shown time into minutes, seconds and hundredths
// ----------------------------------------------------------------------------
//
// channel  direction  handshake               payload
// in       sink       in_valid / in_ready     op, now, lap_index, time_value
// out      source     out_valid / out_ready   mode, elapsed, lap_count, lap_valid,
//                                              shown_time, minutes, seconds, hundredths
//
// one transfer in per cycle while the output is not stalled; a result passes
// through the input register, the command stage with lap memory read and three
// reciprocal multiply stages, the last one being the output register
// reset clears mode, held time, start stamp and lap count; lap memory is not
// cleared, reads beyond the lap count return zero
// every stage advances on its own, so a stalled result keeps upstream stages
// filling until the pipeline is full
//
module lap_stopwatch #(
	parameter int LAP_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [31:0] now,
	input  logic [2:0]  lap_index,
	input  logic [31:0] time_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  mode,
	output logic [31:0] elapsed,
	output logic [3:0]  lap_count,
	output logic        lap_valid,
	output logic [31:0] shown_time,
	output logic [7:0]  minutes,
	output logic [5:0]  seconds,
	output logic [6:0]  hundredths
);

	// input register
	logic        v_s1;
	logic [2:0]  op_s1;
	logic [31:0] now_s1;
	logic [2:0]  idx_s1;
	logic [31:0] tv_s1;

	// command stage output
	logic           v_s2;
	logic           adv_s1;
	logic           fmt_ready;
	lsw_pkg::stat_t stat_s2;
	logic [31:0]    shown_s2;
	lsw_pkg::stat_t stat_res;

	// the command stage moves when the stage after it can take it
	assign adv_s1   = v_s1 && (!v_s2 || fmt_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (fmt_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= op;
			now_s1 <= now;
			idx_s1 <= lap_index;
			tv_s1  <= time_value;
		end
	end

	// state update, lap store and shown time selection
	lsw_ctrl #(
		.LAP_DEPTH(LAP_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv_s1),
		.op        (op_s1),
		.now       (now_s1),
		.lap_index (idx_s1),
		.time_value(tv_s1),
		.stat_s2   (stat_s2),
		.shown_s2  (shown_s2)
	);

	// split into minutes, seconds and hundredths
	lsw_fmt u_fmt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (fmt_ready),
		.stat_in   (stat_s2),
		.shown_in  (shown_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat_out  (stat_res),
		.shown_out (shown_time),
		.minutes   (minutes),
		.seconds   (seconds),
		.hundredths(hundredths)
	);

	assign mode      = stat_res.mode;
	assign elapsed   = stat_res.elapsed;
	assign lap_count = stat_res.lap_count;
	assign lap_valid = stat_res.lap_valid;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the lap stopwatch
// a queue of commands feeds a valid/ready driver; every accepted transfer is
// run through a behavioral copy of the stopwatch; a monitor with random
// back-pressure compares each readout field by field against the oldest
// predicted one
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LAP_DEPTH = 8;
	localparam int RANDOM_ITEMS = 1900;
	localparam int MAX_REPORTS = 40;
	// op code the block has no command for
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// one command transfer
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now;
		logic [2:0]  idx;
		logic [31:0] tv;
	} command_t;

	// one readout transfer
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] elapsed;
		logic [3:0]  lap_count;
		logic        lap_valid;
		logic [31:0] shown;
		logic [7:0]  minutes;
		logic [5:0]  seconds;
		logic [6:0]  hundredths;
	} readout_t;

	// dut ports, all inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = lsw_pkg::OP_START;
	logic [31:0] now = '0;
	logic [2:0]  lap_index = '0;
	logic [31:0] time_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  mode;
	logic [31:0] elapsed;
	logic [3:0]  lap_count;
	logic        lap_valid;
	logic [31:0] shown_time;
	logic [7:0]  minutes;
	logic [5:0]  seconds;
	logic [6:0]  hundredths;

	// stimulus and scoreboard
	command_t    pending[$];
	readout_t    due_readouts[$];
	command_t    cur_cmd;
	logic [31:0] tick;
	int unsigned n_items = 0;
	int unsigned n_accepted;
	int unsigned n_checked;
	int unsigned errors = 0;
	int unsigned n_laps = 0;
	int unsigned n_shifts = 0;
	int unsigned n_valid_reads = 0;

	// idle control for both sides
	int unsigned in_wait;
	int unsigned out_wait;
	int unsigned out_draw;
	bit          quiet_in;
	bit          quiet_out;

	// behavioral copy of the stopwatch state
	logic [1:0]  w_mode = lsw_pkg::MODE_IDLE;
	logic [31:0] w_stamp = '0;
	logic [31:0] w_held = '0;
	int unsigned w_count = 0;
	logic [31:0] w_laps [LAP_DEPTH];

	lap_stopwatch #(
		.LAP_DEPTH(LAP_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.now(now),
		.lap_index(lap_index),
		.time_value(time_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mode(mode),
		.elapsed(elapsed),
		.lap_count(lap_count),
		.lap_valid(lap_valid),
		.shown_time(shown_time),
		.minutes(minutes),
		.seconds(seconds),
		.hundredths(hundredths)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	// idle length per transfer: mostly short, sometimes long, none in quiet stretches
	function automatic int unsigned pick_wait(input bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		return $urandom_range(4, 16);
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at readout %0d: %s", n_checked, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// apply one command to the stopwatch copy and queue the readout it gives
	task automatic step_watch(input command_t c);
		readout_t    r;
		logic [31:0] shown;
		logic [31:0] mins;
		logic [31:0] secs;
		logic [31:0] hund;
		int          i;
		r = '0;
		case (c.op)
			lsw_pkg::OP_START: begin
				w_mode = lsw_pkg::MODE_RUN;
				w_held = '0;
				w_stamp = c.now;
			end
			lsw_pkg::OP_RESET: begin
				// laps are forgotten, start stamp survives
				w_mode = lsw_pkg::MODE_IDLE;
				w_count = 0;
				w_held = '0;
			end
			lsw_pkg::OP_TOGGLE: begin
				if (w_mode == lsw_pkg::MODE_RUN) begin
					w_held = c.now - w_stamp;
					w_mode = lsw_pkg::MODE_PAUSE;
				end else if (w_mode == lsw_pkg::MODE_PAUSE) begin
					// back-date the stamp so the held time carries on
					w_stamp = c.now - w_held;
					w_mode = lsw_pkg::MODE_RUN;
				end
			end
			lsw_pkg::OP_REFRESH: begin
				if (w_mode == lsw_pkg::MODE_RUN)
					w_held = c.now - w_stamp;
			end
			lsw_pkg::OP_LAP: begin
				// paused or idle: the held time is stored as it is
				if (w_mode == lsw_pkg::MODE_RUN)
					w_held = c.now - w_stamp;
				n_laps++;
				if (w_count < LAP_DEPTH) begin
					w_laps[w_count] = w_held;
					w_count++;
				end else begin
					// full store drops the oldest lap
					for (i = 0; i < LAP_DEPTH - 1; i++)
						w_laps[i] = w_laps[i + 1];
					w_laps[LAP_DEPTH - 1] = w_held;
					n_shifts++;
				end
			end
			default: begin
			end
		endcase

		shown = w_held;
		if (c.op == lsw_pkg::OP_READ) begin
			// reads past the count show zero and never touch the store
			if (c.idx < w_count) begin
				r.lap_valid = 1'b1;
				shown = w_laps[c.idx];
				n_valid_reads++;
			end else begin
				shown = '0;
			end
		end else if (c.op == lsw_pkg::OP_FORMAT) begin
			shown = c.tv;
		end

		mins = shown / 60000;
		if (mins > 255)
			mins = 255;
		secs = (shown / 1000) % 60;
		hund = (shown % 1000) / 10;

		r.mode = w_mode;
		r.elapsed = w_held;
		r.lap_count = w_count[3:0];
		r.shown = shown;
		r.minutes = mins[7:0];
		r.seconds = secs[5:0];
		r.hundredths = hund[6:0];
		due_readouts.push_back(r);
	endtask

	// compare the readout on the output ports with the oldest prediction
	task automatic check_readout();
		readout_t want;
		if (due_readouts.size() == 0) begin
			report_mismatch("readout with no command waiting for it");
		end else begin
			want = due_readouts.pop_front();
			check_field("mode", 32'(mode), 32'(want.mode));
			check_field("elapsed", elapsed, want.elapsed);
			check_field("lap_count", 32'(lap_count), 32'(want.lap_count));
			check_field("lap_valid", 32'(lap_valid), 32'(want.lap_valid));
			check_field("shown_time", shown_time, want.shown);
			check_field("minutes", 32'(minutes), 32'(want.minutes));
			check_field("seconds", 32'(seconds), 32'(want.seconds));
			check_field("hundredths", 32'(hundredths), 32'(want.hundredths));
		end
	endtask

	task automatic add_cmd(input logic [2:0] c_op, input logic [31:0] c_now,
			input logic [2:0] c_idx, input logic [31:0] c_tv);
		command_t c;
		c.op = c_op;
		c.now = c_now;
		c.idx = c_idx;
		c.tv = c_tv;
		pending.push_back(c);
		n_items++;
	endtask

	// an optional reset and a start, then a run of commands on a steadily advancing tick
	task automatic play_session();
		int unsigned len;
		int unsigned k;
		int unsigned r;
		logic [2:0]  c_op;
		logic [31:0] c_tv;
		logic [31:0] step;
		// some sessions sit just below the tick wrap
		if ($urandom_range(0, 7) == 0)
			tick = 32'hFFFF_FFFF - $urandom_range(0, 300000);
		else if ($urandom_range(0, 3) == 0)
			tick = $urandom;
		if ($urandom_range(0, 1) == 1)
			add_cmd(lsw_pkg::OP_RESET, tick, 3'($urandom), $urandom);
		add_cmd(lsw_pkg::OP_START, tick, 3'($urandom), $urandom);
		len = $urandom_range(4, 30);
		for (k = 0; k < len; k++) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				step = $urandom_range(0, 5000);
			else if (r < 9)
				step = $urandom_range(0, 2000000);
			else
				step = $urandom;
			tick = tick + step;
			r = $urandom_range(0, 99);
			if (r < 25)
				c_op = lsw_pkg::OP_LAP;
			else if (r < 40)
				c_op = lsw_pkg::OP_REFRESH;
			else if (r < 55)
				c_op = lsw_pkg::OP_TOGGLE;
			else if (r < 75)
				c_op = lsw_pkg::OP_READ;
			else if (r < 87)
				c_op = lsw_pkg::OP_FORMAT;
			else if (r < 92)
				c_op = lsw_pkg::OP_START;
			else if (r < 96)
				c_op = OP_UNUSED;
			else
				c_op = lsw_pkg::OP_RESET;
			// format values near the minute saturation point one time in four
			if ($urandom_range(0, 3) == 0)
				c_tv = $urandom_range(0, 16000000);
			else
				c_tv = $urandom;
			add_cmd(c_op, tick, 3'($urandom), c_tv);
		end
	endtask

	// command driver: one transfer at a time, random gap after each one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= lsw_pkg::OP_START;
			now <= '0;
			lap_index <= '0;
			time_value <= '0;
			in_wait <= 0;
			n_accepted <= 0;
			quiet_in <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				step_watch(cur_cmd);
				n_accepted <= n_accepted + 1;
			end
			// the channel is free when nothing is offered or the offer was just taken
			if (!in_valid || in_ready) begin
				if (in_wait != 0) begin
					in_valid <= 1'b0;
					in_wait <= in_wait - 1;
				end else if (pending.size() != 0) begin
					cur_cmd = pending.pop_front();
					op <= cur_cmd.op;
					now <= cur_cmd.now;
					lap_index <= cur_cmd.idx;
					time_value <= cur_cmd.tv;
					in_valid <= 1'b1;
					in_wait <= pick_wait(quiet_in);
					if ($urandom_range(0, 47) == 0)
						quiet_in <= !quiet_in;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// readout monitor: checks each transfer, then stalls for a random spell
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
			n_checked <= 0;
			quiet_out <= 1'b0;
		end else if (out_valid && out_ready) begin
			check_readout();
			n_checked <= n_checked + 1;
			out_draw = pick_wait(quiet_out);
			if (out_draw == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				out_wait <= out_draw - 1;
			end
			if ($urandom_range(0, 47) == 0)
				quiet_out <= !quiet_out;
		end else if (!out_ready) begin
			if (out_wait == 0)
				out_ready <= 1'b1;
			else
				out_wait <= out_wait - 1;
		end
	end

	// stimulus, end of run and verdict
	initial begin
		int unsigned base;
		int          k;

		// directed part: idle corner cases first
		// read with an empty store
		add_cmd(lsw_pkg::OP_READ, 32'h0, 3'd7, 32'h0);
		// no command, shows elapsed
		add_cmd(OP_UNUSED, 32'hFFFF_FFFF, 3'd0, 32'h0);
		// toggle does nothing when idle
		add_cmd(lsw_pkg::OP_TOGGLE, 32'h1234_5678, 3'd0, 32'h0);
		add_cmd(lsw_pkg::OP_REFRESH, 32'h0000_0100, 3'd0, 32'h0);
		// lap while idle keeps zero
		add_cmd(lsw_pkg::OP_LAP, 32'h0000_0200, 3'd0, 32'h0);
		// start just below the wrap so the first refresh crosses it
		add_cmd(lsw_pkg::OP_START, 32'hFFFF_FF00, 3'd0, 32'h0);
		add_cmd(lsw_pkg::OP_REFRESH, 32'h0000_0100, 3'd0, 32'h0);
		// pause
		add_cmd(lsw_pkg::OP_TOGGLE, 32'h0000_1000, 3'd0, 32'h0);
		// lap while paused keeps held time
		add_cmd(lsw_pkg::OP_LAP, 32'h0400_0000, 3'd0, 32'h0);
		add_cmd(lsw_pkg::OP_REFRESH, 32'h8000_0000, 3'd0, 32'h0);
		// resume across the wrap
		add_cmd(lsw_pkg::OP_TOGGLE, 32'hFFFF_FFF0, 3'd0, 32'h0);
		// fill the store and push one lap past it
		for (k = 1; k <= 7; k++)
			add_cmd(lsw_pkg::OP_LAP, 32'hFFFF_FFF0 + k * 61234567, 3'd0, 32'h0);
		add_cmd(lsw_pkg::OP_READ, 32'h0, 3'd0, 32'h0);
		add_cmd(lsw_pkg::OP_READ, 32'h0, 3'd7, 32'h0);
		add_cmd(lsw_pkg::OP_FORMAT, 32'h0, 3'd0, 32'h0);
		// last value below saturation
		add_cmd(lsw_pkg::OP_FORMAT, 32'h0, 3'd0, 32'd15359999);
		add_cmd(lsw_pkg::OP_FORMAT, 32'h0, 3'd0, 32'hFFFF_FFFF);
		// restart keeps the laps
		add_cmd(lsw_pkg::OP_START, 32'h0, 3'd0, 32'h0);
		add_cmd(lsw_pkg::OP_RESET, 32'h0, 3'd0, 32'h0);
		// laps gone after reset
		add_cmd(lsw_pkg::OP_READ, 32'h0, 3'd0, 32'h0);

		// random part: mostly coherent sessions, some raw noise
		base = n_items;
		tick = $urandom;
		while (n_items - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				play_session();
			end else begin
				for (k = $urandom_range(1, 6); k > 0; k--)
					add_cmd(3'($urandom), $urandom, 3'($urandom), $urandom);
			end
		end

		// reset held from time zero, released once
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// every command taken and every readout back
		while (n_accepted != n_items || n_checked != n_accepted)
			@(posedge clk);
		// room for any readout the block should not have produced
		repeat (12) @(posedge clk);
		if (due_readouts.size() != 0)
			report_mismatch($sformatf("%0d readouts never arrived", due_readouts.size()));

		$display("run covered %0d commands and %0d readouts, %0d mismatches",
			n_accepted, n_checked, errors);
		$display("laps recorded %0d (%0d into a full store), valid lap reads %0d",
			n_laps, n_shifts, n_valid_reads);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#20_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
